// ===== hw/rtl/bpq_pkg.sv =====
// Package for the bounded priority queue: operation codes and the
// command group that the controller sends to the datapath.
// It depends on nothing else.
`default_nettype none
package bpq_pkg;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_CLEAR  = 2'd2
    } func_t;

    localparam int DATA_W = 32;
    localparam int PRIO_W = 16;
    localparam int CNT_OUT_W = 5;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bpq_ctrl.sv =====
// Controller state machine of the bounded priority queue.
// It sequences capture, execution and result hand-off; it uses bpq_pkg.
`default_nettype none
module bpq_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output bpq_pkg::ctrl_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready    = (state_reg == ST_IDLE);
    assign m_tvalid    = (state_reg == ST_OUT);
    assign cmd.capture = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.execute = (state_reg == ST_EXEC);

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> cmd.execute)
        else $error("Accepted word was not executed in the next cycle.");

    a_exec_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute |=> (m_tvalid && !s_tready))
        else $error("Execution was not followed by a pending result.");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && !cmd.execute))
        else $error("Result was withdrawn before it was taken.");

endmodule
`default_nettype wire

// ===== hw/rtl/bpq_datapath.sv =====
// Datapath of the bounded priority queue: a sorted shift-register array,
// the fill count and the result register. It uses bpq_pkg.
`default_nettype none
module bpq_datapath #(
    parameter int CAPACITY = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire bpq_pkg::ctrl_cmd_t                cmd,
    input  wire logic [1:0]                        in_func,
    input  wire logic signed [bpq_pkg::DATA_W-1:0] in_data,
    input  wire logic signed [bpq_pkg::PRIO_W-1:0] in_prio,
    output logic                                   res_valid,
    output logic signed [bpq_pkg::DATA_W-1:0]      res_data,
    output logic signed [bpq_pkg::PRIO_W-1:0]      res_prio,
    output logic                                   res_dropped,
    output logic [bpq_pkg::CNT_OUT_W-1:0]          res_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    // Slot 0 holds the most urgent entry; priorities rise toward the top.
    logic signed [bpq_pkg::DATA_W-1:0] slot_data_reg [CAPACITY];
    logic signed [bpq_pkg::PRIO_W-1:0] slot_prio_reg [CAPACITY];
    logic signed [bpq_pkg::DATA_W-1:0] slot_data_next [CAPACITY];
    logic signed [bpq_pkg::PRIO_W-1:0] slot_prio_next [CAPACITY];
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    bpq_pkg::func_t                    op_func_reg;
    logic signed [bpq_pkg::DATA_W-1:0] op_data_reg;
    logic signed [bpq_pkg::PRIO_W-1:0] op_prio_reg;

    logic                              res_valid_reg;
    logic signed [bpq_pkg::DATA_W-1:0] res_data_reg;
    logic signed [bpq_pkg::PRIO_W-1:0] res_prio_reg;
    logic                              res_dropped_reg;
    logic [bpq_pkg::CNT_OUT_W-1:0]     res_count_reg;

    logic                              valid_next;
    logic signed [bpq_pkg::DATA_W-1:0] data_next;
    logic signed [bpq_pkg::PRIO_W-1:0] prio_next;
    logic                              dropped_next;

    logic [CAPACITY-1:0] le_mask;
    logic [CAPACITY-1:0] ins_mask;

    always_comb begin
        for (int j = 0; j < CAPACITY; j++) begin
            le_mask[j] = (CW'(j) < cnt_reg) && (slot_prio_reg[j] <= op_prio_reg);
        end
        for (int j = 0; j < CAPACITY; j++) begin
            if (j == 0) begin
                ins_mask[j] = !le_mask[j];
            end else begin
                ins_mask[j] = !le_mask[j] && le_mask[j-1];
            end
        end
    end

    always_comb begin
        slot_data_next = slot_data_reg;
        slot_prio_next = slot_prio_reg;
        cnt_next       = cnt_reg;
        valid_next     = 1'b0;
        data_next      = '0;
        prio_next      = '0;
        dropped_next   = 1'b0;
        case (op_func_reg)
            bpq_pkg::FUNC_ADD: begin
                // On a full queue the top slot falls off; when the newcomer
                // ranks above every held entry there is no slot to fill.
                slot_data_next[0] = ins_mask[0] ? op_data_reg : slot_data_reg[0];
                slot_prio_next[0] = ins_mask[0] ? op_prio_reg : slot_prio_reg[0];
                for (int j = 1; j < CAPACITY; j++) begin
                    if (le_mask[j]) begin
                        slot_data_next[j] = slot_data_reg[j];
                        slot_prio_next[j] = slot_prio_reg[j];
                    end else if (ins_mask[j]) begin
                        slot_data_next[j] = op_data_reg;
                        slot_prio_next[j] = op_prio_reg;
                    end else begin
                        slot_data_next[j] = slot_data_reg[j-1];
                        slot_prio_next[j] = slot_prio_reg[j-1];
                    end
                end
                if (cnt_reg == CW'(CAPACITY)) begin
                    dropped_next = 1'b1;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            bpq_pkg::FUNC_REMOVE: begin
                if (cnt_reg != '0) begin
                    valid_next = 1'b1;
                    data_next  = slot_data_reg[0];
                    prio_next  = slot_prio_reg[0];
                    for (int j = 0; j < CAPACITY - 1; j++) begin
                        slot_data_next[j] = slot_data_reg[j+1];
                        slot_prio_next[j] = slot_prio_reg[j+1];
                    end
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            bpq_pkg::FUNC_CLEAR: begin
                cnt_next = '0;
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.execute) begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_func_reg <= bpq_pkg::func_t'(in_func);
            op_data_reg <= in_data;
            op_prio_reg <= in_prio;
        end
        if (cmd.execute) begin
            slot_data_reg   <= slot_data_next;
            slot_prio_reg   <= slot_prio_next;
            res_valid_reg   <= valid_next;
            res_data_reg    <= data_next;
            res_prio_reg    <= prio_next;
            res_dropped_reg <= dropped_next;
            res_count_reg   <= bpq_pkg::CNT_OUT_W'(cnt_next);
        end
    end

    assign res_valid   = res_valid_reg;
    assign res_data    = res_data_reg;
    assign res_prio    = res_prio_reg;
    assign res_dropped = res_dropped_reg;
    assign res_count   = res_count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(CAPACITY))
        else $error("Fill count exceeds the capacity.");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.execute && op_func_reg == bpq_pkg::FUNC_CLEAR) |=> (cnt_reg == '0))
        else $error("Clear left entries in the queue.");

    a_pop_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.execute && op_func_reg == bpq_pkg::FUNC_REMOVE && cnt_reg != '0)
        |=> (res_valid && res_prio == $past(slot_prio_reg[0])))
        else $error("Remove did not return the most urgent entry.");

    a_count_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.execute |=> $stable(cnt_reg))
        else $error("Fill count changed outside execution.");

endmodule
`default_nettype wire

// ===== hw/rtl/bounded_priority_queue_top.sv =====
// A word is captured when accepted, executed in the EXEC state, and its result word is
// registered as the controller enters the output state. The controller handles one
// word at a time (capture, execute, result hand-off) and accepts no new word until the result is taken.
// Reset: aresetn is synchronous and active low; it empties the queue and idles the
// controller. Slot contents are not cleared and no clearing pass is needed.
`default_nettype none
module bounded_priority_queue_top #(
    parameter int CAPACITY = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // Fields from bit 0: item_data[31:0], item_priority[47:32].
    input  wire logic [47:0] s_tdata,
    // Fields from bit 0: func[1:0].
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // Fields from bit 0: out_data[31:0], out_priority[47:32], dropped[48],
    // entry_count[53:49], zero fill[55:54].
    output logic [55:0]      m_tdata,
    // Fields from bit 0: out_valid[0].
    output logic [0:0]       m_tuser
);

    bpq_pkg::ctrl_cmd_t cmd;

    logic                              res_valid;
    logic signed [bpq_pkg::DATA_W-1:0] res_data;
    logic signed [bpq_pkg::PRIO_W-1:0] res_prio;
    logic                              res_dropped;
    logic [bpq_pkg::CNT_OUT_W-1:0]     res_count;

    bpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    bpq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_func     (s_tuser),
        .in_data     (s_tdata[31:0]),
        .in_prio     (s_tdata[47:32]),
        .res_valid   (res_valid),
        .res_data    (res_data),
        .res_prio    (res_prio),
        .res_dropped (res_dropped),
        .res_count   (res_count)
    );

    assign m_tdata = {2'b00, res_count, res_dropped, res_prio, res_data};
    assign m_tuser = res_valid;

endmodule
`default_nettype wire
